// ===== rtl/link_presence_exchange_core_macros.svh =====
// Assertion macros shared by the link presence exchange checker.
`ifndef LINK_PRESENCE_EXCHANGE_CORE_MACROS_SVH
`define LINK_PRESENCE_EXCHANGE_CORE_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define LPX_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check an implication on every clock edge, reset included.
`define LPX_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lpx_pkg.sv =====
// Types, constants and helpers for the link presence exchange core.
package lpx_pkg;

    localparam int unsigned ValueW = 8;
    localparam int unsigned LocalW = 3;

    localparam logic [ValueW-1:0] FrameCheckMask  = 8'h88;
    localparam logic [ValueW-1:0] FrameCheckValue = 8'h80;
    localparam logic [LocalW-1:0] PayloadMask     = 3'h7;

    localparam logic [ValueW-1:0] SendIntervalRst = 8'd30;
    localparam logic [ValueW-1:0] RxTimeoutRst    = 8'd120;
    localparam logic [ValueW-1:0] DisconnectRst   = 8'd255;

    // Item kinds carried in tuser
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SERIAL = 1'b1
    } lpx_op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SEND_INTERVAL = 2'd0,
        REG_RX_TIMEOUT    = 2'd1,
        REG_DISC_CODE     = 2'd2
    } lpx_reg_t;

    typedef struct packed {
        logic [ValueW-1:0] send_interval;
        logic [ValueW-1:0] receive_timeout;
        logic [ValueW-1:0] disconnected_code;
    } lpx_cfg_t;

    typedef struct packed {
        lpx_op_t           opcode;
        logic [LocalW-1:0] local_value;
        logic [ValueW-1:0] rx_byte;
        logic              internal_clock;
    } lpx_item_t;

    typedef struct packed {
        logic              send_valid;
        logic [ValueW-1:0] send_byte;
        logic              changed;
        logic [ValueW-1:0] partner_value;
        logic              rearm_receive;
    } lpx_result_t;

    // Build the framed byte: marker bit, inverted copy, payload
    function automatic logic [ValueW-1:0] frame_byte(input logic [LocalW-1:0] v);
        frame_byte = FrameCheckValue | {1'b0, v ^ PayloadMask, 1'b0, v};
    endfunction

    // Accept a received byte when marker bits and inverted copy agree
    function automatic logic frame_ok(input logic [ValueW-1:0] b);
        frame_ok = ((b & FrameCheckMask) == FrameCheckValue)
                   && (b[6:4] == (b[2:0] ^ PayloadMask));
    endfunction

endpackage

// ===== rtl/link_presence_exchange_core.sv =====
// Top level of the link presence exchange core: channels, config registers, pipeline.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser opcode, tdata item fields
//  m_      | out | m_tvalid/m_tready  | tdata result fields
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One item per cycle unless the output stalls: an accepted beat sits in the input register
// and moves to the result register on the next edge at which it is free or draining.
// The step logic is a single pass of counter decrements and byte compares.
// Reset is synchronous, active low, and restores all but the data registers to defaults.
// A stalled result holds in the result register; the input register takes one more
// beat, then s_tready drops until the result beat drains.
module link_presence_exchange_core
    import lpx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [0:0]  s_tuser,   // [0] opcode
    input  logic [15:0] s_tdata,   // [2:0] local_value, [10:3] rx_byte,
                                   // [11] internal_clock, [15:12] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] send_valid, [8:1] send_byte, [9] changed,
                                   // [17:10] partner_value, [18] rearm_receive,
                                   // [23:19] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    lpx_cfg_t    cfg_reg;
    logic        in_valid_reg;
    lpx_item_t   in_item_reg;
    logic        out_valid_reg;
    lpx_result_t out_result_reg;
    lpx_result_t step_result;
    logic        advance;
    logic        fire;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.send_interval     <= SendIntervalRst;
            cfg_reg.receive_timeout   <= RxTimeoutRst;
            cfg_reg.disconnected_code <= DisconnectRst;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SEND_INTERVAL: cfg_reg.send_interval     <= cfg_data;
                REG_RX_TIMEOUT:    cfg_reg.receive_timeout   <= cfg_data;
                REG_DISC_CODE:     cfg_reg.disconnected_code <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Pipeline flow: the result register drains or is empty
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.opcode         <= lpx_op_t'(s_tuser[0]);
            in_item_reg.local_value    <= s_tdata[2:0];
            in_item_reg.rx_byte        <= s_tdata[10:3];
            in_item_reg.internal_clock <= s_tdata[11];
        end
    end

    lpx_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_result_reg.rearm_receive,
                       out_result_reg.partner_value,
                       out_result_reg.changed,
                       out_result_reg.send_byte,
                       out_result_reg.send_valid};

endmodule

// ===== rtl/lpx_engine.sv =====
// Presence exchange state: send countdown, receive timeout and partner value tracking.
module lpx_engine
    import lpx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  lpx_item_t   item,
    input  lpx_cfg_t    cfg,
    output lpx_result_t result
);

    logic [ValueW-1:0] send_countdown_reg, send_countdown_next;
    logic [ValueW-1:0] timeout_count_reg, timeout_count_next;
    logic              fresh_data_reg, fresh_data_next;
    logic [ValueW-1:0] received_value_reg, received_value_next;
    logic [ValueW-1:0] reported_value_reg, reported_value_next;

    logic [ValueW-1:0] timeout_loaded;
    logic [ValueW-1:0] reported_loaded;
    logic              changed;

    // Work out the next state and the result beat for the item in front
    always_comb begin
        send_countdown_next = send_countdown_reg;
        timeout_count_next  = timeout_count_reg;
        fresh_data_next     = fresh_data_reg;
        received_value_next = received_value_reg;
        reported_value_next = reported_value_reg;
        timeout_loaded      = timeout_count_reg;
        reported_loaded     = reported_value_reg;
        changed             = 1'b0;
        result              = '0;

        if (item.opcode == OP_TICK) begin
            // Count down to the next periodic transmission
            if (send_countdown_reg != '0) begin
                if (send_countdown_reg == ValueW'(1)) begin
                    result.send_valid   = 1'b1;
                    result.send_byte    = frame_byte(item.local_value);
                    send_countdown_next = cfg.send_interval;
                end else begin
                    send_countdown_next = send_countdown_reg - ValueW'(1);
                end
            end

            // Fresh data restarts the timeout and may report a new value
            if (fresh_data_reg) begin
                timeout_loaded  = cfg.receive_timeout;
                fresh_data_next = 1'b0;
                reported_loaded = received_value_reg;
                changed         = (reported_value_reg != received_value_reg);
            end
            reported_value_next = reported_loaded;
            timeout_count_next  = timeout_loaded;

            // Expire the link when the timeout runs out
            if (timeout_loaded != '0) begin
                timeout_count_next = timeout_loaded - ValueW'(1);
                if (timeout_loaded == ValueW'(1)) begin
                    received_value_next = cfg.disconnected_code;
                    reported_value_next = cfg.disconnected_code;
                    changed             = 1'b1;
                end
            end

            result.changed       = changed;
            result.partner_value = changed ? received_value_next : '0;
        end else begin
            if (item.internal_clock) begin
                result.rearm_receive = 1'b1;
            end else if (frame_ok(item.rx_byte)) begin
                received_value_next = ValueW'(item.rx_byte[LocalW-1:0]);
                fresh_data_next     = 1'b1;
            end
        end
    end

    // Commit state when the item leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_countdown_reg <= SendIntervalRst;
            timeout_count_reg  <= '0;
            fresh_data_reg     <= 1'b0;
            received_value_reg <= DisconnectRst;
            reported_value_reg <= DisconnectRst;
        end else if (fire) begin
            send_countdown_reg <= send_countdown_next;
            timeout_count_reg  <= timeout_count_next;
            fresh_data_reg     <= fresh_data_next;
            received_value_reg <= received_value_next;
            reported_value_reg <= reported_value_next;
        end
    end

endmodule

// ===== rtl/lpx_checker.sv =====
// Port-level checker for the link presence exchange core, bound to the top level.
`include "link_presence_exchange_core_macros.svh"

module lpx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic       send_valid;
    logic [7:0] send_byte;
    logic       changed;
    logic [7:0] partner_value;
    logic       rearm;
    logic [4:0] pad;
    logic       stalled;
    logic       frame_good;
    logic       send_ok;
    logic       rearm_ok;
    logic       partner_ok;

    // Split the result beat into its fields
    assign send_valid    = m_tdata[0];
    assign send_byte     = m_tdata[8:1];
    assign changed       = m_tdata[9];
    assign partner_value = m_tdata[17:10];
    assign rearm         = m_tdata[18];
    assign pad           = m_tdata[23:19];
    assign stalled       = m_tvalid && !m_tready;

    // A sent byte carries the marker and the inverted copy; no send means a zero byte
    assign frame_good = send_byte[7] && !send_byte[3] && (send_byte[6:4] == ~send_byte[2:0]);
    assign send_ok    = send_valid ? frame_good : (send_byte == 8'h00);

    // A re-arm beat comes from a serial event and carries nothing else
    assign rearm_ok = !rearm || (m_tdata[17:0] == 18'h0);

    // Partner value is zero unless a change is reported; padding stays zero
    assign partner_ok = (changed || (partner_value == 8'h00)) && (pad == 5'h0);

    // Stalled result beat stays presented
    `LPX_ASSERT(a_hold_stalled, aclk, aresetn, stalled |=> (m_tvalid && $stable(m_tdata)), "beat not held")

    `LPX_ASSERT(a_send_frame, aclk, aresetn, m_tvalid |-> send_ok, "bad framed byte")

    `LPX_ASSERT(a_rearm_alone, aclk, aresetn, m_tvalid |-> rearm_ok, "re-arm beat with other fields set")

    `LPX_ASSERT(a_partner_zero, aclk, aresetn, m_tvalid |-> partner_ok, "partner value without change")

    // No result beat right after reset
    `LPX_ASSERT_ALWAYS(a_reset_empty, aclk, $rose(aresetn) |-> !m_tvalid, "result valid after reset")

endmodule

bind link_presence_exchange_core lpx_checker u_lpx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
